// ===== sv/mpqm_pkg.sv =====
// Package for the message pool queue manager.
// Holds the command and status codes and the item structs; depends on nothing.
package mpqm_pkg;

  localparam int CFG_REGS = 4;
  localparam logic [7:0] LIMIT_RESET = 8'd16;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_FREE = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_EXHAUSTED = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_NOFREE    = 3'd4
  } status_e_t;

  typedef struct packed {
    cmd_e_t             command;
    logic [1:0]         queue_id;
    logic signed [31:0] signal_value;
    logic [3:0]         slot_handle;
  } in_item_t;

  typedef struct packed {
    status_e_t          status;
    logic [3:0]         out_handle;
    logic signed [31:0] out_signal;
    logic [4:0]         slots_in_use;
  } out_item_t;

endpackage

// ===== sv/message_pool_queue_manager.sv =====
// Top level of the message pool queue manager: command sequencer, queue registers
// and signal memory. Depends on mpqm_pkg and mpqm_link_mem.
//
// Usage. A command item is taken on in_item when start is high and busy is low.
// Every command gives exactly one result item on out_item, marked by out_valid for
// a single cycle; the receiver cannot hold it off, so it must take it then.
// The accepted command passes through the EXEC state, from which out_valid and
// out_item are registered. A get, a free, a refused put or a no-operation keeps
// busy high only in EXEC; an accepted put also holds it in WR2, so a new command
// is taken only once the last is through. The link memory sets this: its read is
// registered, and its single write port needs WR2 for a put, which writes the old
// tail link in EXEC (queue not empty) and then clears the new slot's link.
// Queue limits are written through the cfg channel, which is always ready; the user
// must use it only while the block is idle, as the block does not enforce this. At
// reset the free list holds every slot in order, all queues are empty, the limits
// return to 16 and no result is pending; the link memory needs no clearing pass.
module message_pool_queue_manager #(
  parameter int POOL_SLOTS  = 16,
  parameter int QUEUE_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mpqm_pkg::in_item_t in_item,
  output logic               out_valid,
  output mpqm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  import mpqm_pkg::*;

  localparam int SW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WR2  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  cmd_e_t             cmd_r;
  logic [1:0]         q_r;
  logic               qok_r;
  logic signed [31:0] sig_r;
  logic [3:0]         h_r;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic [SW-1:0]      free_head_r, free_head_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [SW-1:0]      qhead_r [QUEUE_COUNT];
  logic [SW-1:0]      qhead_nxt [QUEUE_COUNT];
  logic [SW-1:0]      qtail_r [QUEUE_COUNT];
  logic [SW-1:0]      qtail_nxt [QUEUE_COUNT];
  logic [7:0]         qlen_r [QUEUE_COUNT];
  logic [7:0]         qlen_nxt [QUEUE_COUNT];
  logic [7:0]         limit_r [CFG_REGS];
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic signed [31:0] sig_mem [POOL_SLOTS];
  logic signed [31:0] sig_rd_r;
  logic               sg_we;

  logic               accept;
  logic               in_qok;
  logic [QW-1:0]      in_qi;
  logic [QW-1:0]      qi;
  logic [SW-1:0]      h_slot;
  logic               rd_en;
  logic [SW-1:0]      rd_addr;
  logic [SW-1:0]      lk_rd;
  logic               lk_we;
  logic [SW-1:0]      lk_waddr;
  logic [SW-1:0]      lk_wdata;

  mpqm_link_mem #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_link_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(lk_rd),
    .wr_en  (lk_we),
    .wr_addr(lk_waddr),
    .wr_data(lk_wdata)
  );

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign in_qok  = 3'(in_item.queue_id) < 3'(QUEUE_COUNT);
  assign in_qi   = QW'(in_item.queue_id);
  assign qi      = QW'(q_r);
  assign h_slot  = SW'(h_r);
  assign rd_en   = accept;
  assign rd_addr = (in_item.command == CMD_GET && in_qok) ? qhead_r[in_qi] : free_head_r;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    free_head_nxt = free_head_r;
    used_nxt      = used_r;
    qhead_nxt     = qhead_r;
    qtail_nxt     = qtail_r;
    qlen_nxt      = qlen_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    lk_we         = 1'b0;
    lk_waddr      = slot_r;
    lk_wdata      = '0;
    sg_we         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt                 = ST_IDLE;
        out_valid_nxt             = 1'b1;
        out_item_nxt.status       = STS_OK;
        out_item_nxt.out_handle   = '0;
        out_item_nxt.out_signal   = '0;
        unique case (cmd_r)
          CMD_PUT: begin
            if (!qok_r || qlen_r[qi] >= limit_r[q_r]) begin
              out_item_nxt.status = STS_FULL;
            end else if (used_r == CW'(POOL_SLOTS)) begin
              out_item_nxt.status = STS_EXHAUSTED;
            end else begin
              slot_nxt      = free_head_r;
              free_head_nxt = lk_rd;
              used_nxt      = used_r + CW'(1);
              sg_we         = 1'b1;
              if (qlen_r[qi] == 8'd0) begin
                qhead_nxt[qi] = free_head_r;
                qlen_nxt[qi]  = 8'd1;
              end else begin
                lk_we        = 1'b1;
                lk_waddr     = qtail_r[qi];
                lk_wdata     = free_head_r;
                qlen_nxt[qi] = qlen_r[qi] + 8'd1;
              end
              qtail_nxt[qi]           = free_head_r;
              out_item_nxt.out_handle = 4'(free_head_r);
              state_nxt               = ST_WR2;
            end
          end
          CMD_GET: begin
            if (!qok_r || qlen_r[qi] == 8'd0) begin
              out_item_nxt.status = STS_EMPTY;
            end else begin
              if (qlen_r[qi] == 8'd1) begin
                qhead_nxt[qi] = '0;
                qtail_nxt[qi] = '0;
                qlen_nxt[qi]  = 8'd0;
              end else begin
                qhead_nxt[qi] = lk_rd;
                qlen_nxt[qi]  = qlen_r[qi] - 8'd1;
              end
              out_item_nxt.out_handle = 4'(qhead_r[qi]);
              out_item_nxt.out_signal = sig_rd_r;
            end
          end
          CMD_FREE: begin
            if (used_r == '0 || 9'(h_r) >= 9'(POOL_SLOTS)) begin
              out_item_nxt.status = STS_NOFREE;
            end else begin
              lk_we         = 1'b1;
              lk_waddr      = h_slot;
              lk_wdata      = free_head_r;
              free_head_nxt = h_slot;
              used_nxt      = used_r - CW'(1);
            end
          end
          CMD_NOP: begin
          end
          default: begin
          end
        endcase
        out_item_nxt.slots_in_use = 5'(used_nxt);
      end
      ST_WR2: begin
        lk_we     = 1'b1;
        lk_waddr  = slot_r;
        lk_wdata  = '0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_head_r <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        qhead_r[i] <= '0;
        qtail_r[i] <= '0;
        qlen_r[i]  <= '0;
      end
      for (int i = 0; i < CFG_REGS; i++) begin
        limit_r[i] <= LIMIT_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      qhead_r     <= qhead_nxt;
      qtail_r     <= qtail_nxt;
      qlen_r      <= qlen_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    out_item_r <= out_item_nxt;
    if (accept) begin
      cmd_r <= in_item.command;
      q_r   <= in_item.queue_id;
      qok_r <= in_qok;
      sig_r <= in_item.signal_value;
      h_r   <= in_item.slot_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (sg_we) begin
      sig_mem[free_head_r] <= sig_r;
    end
    if (rd_en) begin
      sig_rd_r <= sig_mem[rd_addr];
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("command accepted without a result two cycles later");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(POOL_SLOTS))
    else $error("used slot count exceeds the pool size");

  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STS_OK) |->
      (out_item.out_handle == '0 && out_item.out_signal == '0))
    else $error("refused command returned a handle or signal");

  a_wr2_after_put: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR2) |-> ($past(state_r) == ST_EXEC && cmd_r == CMD_PUT))
    else $error("link clear cycle without an accepted put");

endmodule

// ===== sv/mpqm_link_mem.sv =====
// Link memory of the slot pool: one write port, one registered read port.
// Unwritten entries read as the next slot index, the last slot as 0; depends on no package.
module mpqm_link_mem #(
  parameter int POOL_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(POOL_SLOTS)-1:0] rd_addr,
  output logic [$clog2(POOL_SLOTS)-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(POOL_SLOTS)-1:0] wr_addr,
  input  logic [$clog2(POOL_SLOTS)-1:0] wr_data
);

  localparam int SW = $clog2(POOL_SLOTS);

  logic [SW-1:0]         mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] vld_r;
  logic [SW-1:0]         mem_q_r;
  logic [SW-1:0]         addr_q_r;
  logic                  vld_q_r;
  logic [SW-1:0]         init_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r  <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
      addr_q_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= vld_r[rd_addr] || (wr_en && wr_addr == rd_addr);
      end
    end
  end

  assign init_val = (addr_q_r == SW'(POOL_SLOTS - 1)) ? '0 : addr_q_r + SW'(1);
  assign rd_data  = vld_q_r ? mem_q_r : init_val;

endmodule
